/* design/alu_nz_pkg.sv */
// ----------------------------------------------------------------------------
// ALU with N/Z flags - shared package
// Action codes, halfword masks, request/response structs and sequencer states.
// ----------------------------------------------------------------------------
package alu_nz_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ACT_W  = 5;
   localparam int unsigned CNT_W  = 5;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_ADD = 5'd0;
   localparam logic [ACT_W-1:0] ACT_SUB = 5'd1;
   localparam logic [ACT_W-1:0] ACT_MUL = 5'd2;
   localparam logic [ACT_W-1:0] ACT_DIV = 5'd3;
   localparam logic [ACT_W-1:0] ACT_CMP = 5'd4;
   localparam logic [ACT_W-1:0] ACT_SHL = 5'd5;
   localparam logic [ACT_W-1:0] ACT_SHR = 5'd6;
   localparam logic [ACT_W-1:0] ACT_AND = 5'd7;
   localparam logic [ACT_W-1:0] ACT_OR  = 5'd8;
   localparam logic [ACT_W-1:0] ACT_XOR = 5'd9;
   localparam logic [ACT_W-1:0] ACT_LDL = 5'd10;
   localparam logic [ACT_W-1:0] ACT_LDH = 5'd11;
   localparam logic [ACT_W-1:0] ACT_NOT = 5'd12;
   localparam logic [ACT_W-1:0] ACT_JZ  = 5'd13;
   localparam logic [ACT_W-1:0] ACT_JP  = 5'd14;
   localparam logic [ACT_W-1:0] ACT_JN  = 5'd15;
   localparam logic [ACT_W-1:0] ACT_JNZ = 5'd16;
   localparam logic [ACT_W-1:0] ACT_JNP = 5'd17;
   localparam logic [ACT_W-1:0] ACT_JNN = 5'd18;
   localparam logic [ACT_W-1:0] ACT_MOV = 5'd19;

   localparam logic [DATA_W-1:0] HIGH_HALF  = 32'hFFFF_0000;
   localparam logic [DATA_W-1:0] LOW_HALF   = 32'h0000_FFFF;
   localparam int unsigned       HALF_SHIFT = 16;
   localparam logic [4:0]        SHIFT_MAX  = 5'd31;
   localparam logic [CNT_W-1:0]  LAST_STEP  = 5'd31;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic signed [DATA_W-1:0] remainder_value;
      logic                     write_result;
      logic                     write_remainder;
      logic                     branch_taken;
      logic                     divide_by_zero;
      logic                     flag_negative;
      logic                     flag_zero;
   } rsp_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_ABSA = 8'b0000_0100,
      S_ABSB = 8'b0000_1000,
      S_ITER = 8'b0001_0000,
      S_NEGQ = 8'b0010_0000,
      S_NEGR = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

/* design/alu_with_nz_flags_and_branch_test_top.sv */
// ----------------------------------------------------------------------------
// ALU with N/Z flags and branch test - top level
// Execute unit of a 32-bit teaching machine built around one shared 33-bit
// adder/subtractor driven by a small one-hot sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  req     | in  | req_valid / req_stall | req_data  (action, operand_a/b)
//  rsp     | out | rsp_valid / rsp_stall | rsp_data  (result, remainder,
//          |     |                       |  write/branch/dz strobes, flags)
//
//  Steps: a request is taken only in IDLE, which is re-entered as the previous
//  response loads. Add/sub/cmp/logic/shift/load/jump: EXEC, then DONE and the
//  response register. Mul: 32 shift-add steps on the shared adder. Div: two
//  magnitude, 32 restoring, two sign-fix steps; divide by zero goes to DONE.
//  Reset clears the sequencer, the response valid and both flags. A stalled
//  response holds its register; a finished request waits in DONE meanwhile.
// ----------------------------------------------------------------------------
module alu_with_nz_flags_and_branch_test_top
   import alu_nz_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // sequencer and working registers
   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [DATA_W-1:0] x_ff, x_in;     // acc (mul) / partial remainder (div) / a
   logic [DATA_W-1:0] y_ff, y_in;     // multiplicand / divisor / b
   logic [DATA_W-1:0] q_ff, q_in;     // multiplier / dividend -> quotient
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              negq_ff, negq_in;
   logic              negr_ff, negr_in;

   // pending result
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic              wr_ff, wr_in;
   logic              wrem_ff, wrem_in;
   logic              nz_ff, nz_in;
   logic              dz_ff, dz_in;

   // architectural flags
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // shared adder
   logic [DATA_W-1:0] add_x, add_y;
   logic              add_sub;
   logic [DATA_W:0]   add_sum;

   logic [4:0]        sh_amt;
   logic [DATA_W-1:0] div_shift;
   logic              req_fire;
   logic              done_fire;
   logic              taken;
   logic              is_mul, is_div;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign done_fire = (state_ff == S_DONE) & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_mul = (req_data.action == ACT_MUL);
   assign is_div = (req_data.action == ACT_DIV);

   // restoring divide: shift next dividend bit into the partial remainder
   assign div_shift = {x_ff[DATA_W-2:0], q_ff[DATA_W-1]};

   // one adder for everything; carry out high on subtract means no borrow
   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}}
                  + {{DATA_W{1'b0}}, add_sub};

   always_comb begin
      add_x   = x_ff;
      add_y   = y_ff;
      add_sub = 1'b0;
      unique case (state_ff) inside
         S_EXEC: begin
            add_sub = (op_ff != ACT_ADD);
         end
         S_ITER: begin
            if (op_ff == ACT_DIV) begin
               add_x   = div_shift;
               add_sub = 1'b1;
            end
         end
         S_ABSA, S_NEGQ: begin
            add_x   = '0;
            add_y   = q_ff;
            add_sub = 1'b1;
         end
         S_ABSB: begin
            add_x   = '0;
            add_sub = 1'b1;
         end
         S_NEGR: begin
            add_x   = '0;
            add_y   = x_ff;
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // saturated shift amount: negative -> 0, above 31 -> 31
   always_comb begin
      if (y_ff[DATA_W-1]) begin
         sh_amt = '0;
      end else if (|y_ff[DATA_W-2:5]) begin
         sh_amt = SHIFT_MAX;
      end else begin
         sh_amt = y_ff[4:0];
      end
   end

   // branch test on the stored flags
   always_comb begin
      unique case (op_ff)
         ACT_JZ:  taken = zero_ff;
         ACT_JP:  taken = ~zero_ff & ~neg_ff;
         ACT_JN:  taken = neg_ff;
         ACT_JNZ: taken = ~zero_ff;
         ACT_JNP: taken = zero_ff | neg_ff;
         ACT_JNN: taken = ~neg_ff;
         default: taken = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      wr_in    = wr_ff;
      wrem_in  = wrem_ff;
      nz_in    = nz_ff;
      dz_in    = dz_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_data.action;
               x_in    = (is_mul | is_div) ? '0 : req_data.operand_a;
               y_in    = is_mul ? req_data.operand_a : req_data.operand_b;
               q_in    = is_mul ? req_data.operand_b : req_data.operand_a;
               cnt_in  = '0;
               negq_in = req_data.operand_a[DATA_W-1] ^ req_data.operand_b[DATA_W-1];
               negr_in = req_data.operand_a[DATA_W-1];
               wr_in   = 1'b0;
               wrem_in = 1'b0;
               nz_in   = 1'b0;
               dz_in   = 1'b0;
               if (is_div) begin
                  if (req_data.operand_b == '0) begin
                     dz_in    = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_ABSA;
                  end
               end else if (is_mul) begin
                  state_in = S_ITER;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            res_in = '0;
            case (op_ff) inside
               ACT_ADD, ACT_SUB: begin
                  res_in = add_sum[DATA_W-1:0];
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_CMP: begin
                  res_in = add_sum[DATA_W-1:0];
                  nz_in  = 1'b1;
               end
               ACT_SHL: begin
                  res_in = x_ff << sh_amt;
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_SHR: begin
                  res_in = DATA_W'($signed(x_ff) >>> sh_amt);
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_AND: begin
                  res_in = x_ff & y_ff;
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_OR: begin
                  res_in = x_ff | y_ff;
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_XOR: begin
                  res_in = x_ff ^ y_ff;
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_NOT: begin
                  res_in = ~x_ff;
                  wr_in  = 1'b1;
                  nz_in  = 1'b1;
               end
               ACT_LDL: begin
                  res_in = (x_ff & HIGH_HALF) | (y_ff & LOW_HALF);
                  wr_in  = 1'b1;
               end
               ACT_LDH: begin
                  res_in = (x_ff & LOW_HALF) | ((y_ff & LOW_HALF) << HALF_SHIFT);
                  wr_in  = 1'b1;
               end
               ACT_MOV: begin
                  res_in = y_ff;
                  wr_in  = 1'b1;
               end
               default: begin
                  // jumps and unused codes write nothing
                  res_in = '0;
               end
            endcase
            state_in = S_DONE;
         end

         S_ABSA: begin
            if (q_ff[DATA_W-1]) begin
               q_in = add_sum[DATA_W-1:0];
            end
            state_in = S_ABSB;
         end

         S_ABSB: begin
            if (y_ff[DATA_W-1]) begin
               y_in = add_sum[DATA_W-1:0];
            end
            state_in = S_ITER;
         end

         S_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (op_ff == ACT_DIV) begin
               if (add_sum[DATA_W]) begin
                  x_in = add_sum[DATA_W-1:0];
                  q_in = {q_ff[DATA_W-2:0], 1'b1};
               end else begin
                  x_in = div_shift;
                  q_in = {q_ff[DATA_W-2:0], 1'b0};
               end
               if (cnt_ff == LAST_STEP) begin
                  state_in = S_NEGQ;
               end
            end else begin
               // shift-add multiply, low word only
               if (q_ff[0]) begin
                  x_in = add_sum[DATA_W-1:0];
               end
               y_in = y_ff << 1;
               q_in = q_ff >> 1;
               if (cnt_ff == LAST_STEP) begin
                  res_in   = q_ff[0] ? add_sum[DATA_W-1:0] : x_ff;
                  wr_in    = 1'b1;
                  nz_in    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end

         S_NEGQ: begin
            res_in   = negq_ff ? add_sum[DATA_W-1:0] : q_ff;
            wr_in    = 1'b1;
            wrem_in  = 1'b1;
            nz_in    = 1'b1;
            state_in = S_NEGR;
         end

         S_NEGR: begin
            rem_in   = negr_ff ? add_sum[DATA_W-1:0] : x_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (done_fire) begin
               if (nz_ff) begin
                  neg_in  = res_ff[DATA_W-1];
                  zero_in = (res_ff == '0);
               end
               rsp_in.result_value    = wr_ff ? res_ff : '0;
               rsp_in.remainder_value = wrem_ff ? rem_ff : '0;
               rsp_in.write_result    = wr_ff;
               rsp_in.write_remainder = wrem_ff;
               rsp_in.branch_taken    = taken;
               rsp_in.divide_by_zero  = dz_ff;
               rsp_in.flag_negative   = nz_ff ? res_ff[DATA_W-1] : neg_ff;
               rsp_in.flag_zero       = nz_ff ? (res_ff == '0) : zero_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         zero_ff      <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      wr_ff   <= wr_in;
      wrem_ff <= wrem_in;
      nz_ff   <= nz_in;
      dz_ff   <= dz_in;
      rsp_ff  <= rsp_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // flags move only when a finished request is handed to the response reg
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !done_fire |=> $stable({neg_ff, zero_ff}))
      else $error("flags changed outside response load");

   // a new response appears only out of DONE
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without finishing a request");

   // divide by zero writes nothing
   a_dz_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.divide_by_zero |->
         !rsp_ff.write_result && !rsp_ff.write_remainder)
      else $error("divide by zero wrote a result");

   // a remainder only comes with a written quotient
   a_rem_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_remainder |-> rsp_ff.write_result)
      else $error("remainder written without quotient");

endmodule

/* bench/tb_alu_with_nz_flags_and_branch_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU with N/Z flags and branch test - testbench
// Sends a directed set of requests, then 1225 random ones, through the
// request channel with random gaps and random response stalls. Each accepted
// request is run through a local model of the execute unit and its N/Z
// flags. Every response is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_alu_with_nz_flags_and_branch_test_top;
   import alu_nz_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned RANDOM_REQS = 1225;
   localparam int unsigned DRAIN_EVERY = 250;        // sender waits for an empty pipe
   localparam int unsigned TAIL_CYCLES = 60;         // longer than a divide
   localparam logic [ACT_W-1:0] ACT_TOP_CODE = '1;   // highest unused action code

   // One request waiting in the driver queue. When wait_drain is set, the
   // driver holds it back until every outstanding response has come in.
   typedef struct {
      req_type rq;
      bit      wait_drain;
   } pend_req_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pend_req_type pend_q[$];      // requests not yet offered
   rsp_type      alu_out_q[$];   // predicted responses, oldest first

   // Local copy of the flag state, advanced at each accepted request
   logic flag_n_shadow = 1'b0;
   logic flag_z_shadow = 1'b0;

   logic        req_fired = 1'b0;   // request taken at the last rising edge
   int unsigned req_total    = 0;
   int unsigned req_accepted = 0;
   int unsigned err_cnt      = 0;
   int unsigned cycle_cnt    = 0;
   int unsigned gap_left     = 0;
   int unsigned stall_left   = 0;
   int unsigned calm_left[2] = '{0, 0};   // idle-free stretch per side

   alu_with_nz_flags_and_branch_test_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction: one response per request, flags updated in request order
   // -------------------------------------------------------------------------
   function automatic rsp_type exec_alu(req_type rq);
      rsp_type     o;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [31:0] r;
      longint      sa;
      longint      sb;
      int          sh;
      bit          upd;
      o   = '0;
      r   = '0;
      upd = 1'b0;
      ua  = rq.operand_a;
      ub  = rq.operand_b;
      sa  = $signed(ua);
      sb  = $signed(ub);
      // shift amount saturates into 0..31
      sh  = (sb < 0) ? 0 : (sb > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(sb);
      case (rq.action)
         ACT_ADD: begin r = ua + ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_SUB: begin r = ua - ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_MUL: begin r = ua * ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_DIV: begin
            if (sb == 0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               // 64-bit divide keeps -2^31 / -1 from trapping; low word wraps
               r                 = 32'(sa / sb);
               o.remainder_value = 32'(sa % sb);
               o.write_result    = 1'b1;
               o.write_remainder = 1'b1;
               upd               = 1'b1;
            end
         end
         ACT_CMP: begin r = ua - ub; upd = 1'b1; end
         ACT_SHL: begin r = ua << sh; o.write_result = 1'b1; upd = 1'b1; end
         ACT_SHR: begin r = $signed(ua) >>> sh; o.write_result = 1'b1; upd = 1'b1; end
         ACT_AND: begin r = ua & ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_OR:  begin r = ua | ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_XOR: begin r = ua ^ ub; o.write_result = 1'b1; upd = 1'b1; end
         ACT_LDL: begin r = (ua & HIGH_HALF) | (ub & LOW_HALF); o.write_result = 1'b1; end
         ACT_LDH: begin
            r = (ua & LOW_HALF) | ((ub & LOW_HALF) << HALF_SHIFT);
            o.write_result = 1'b1;
         end
         ACT_NOT: begin r = ~ua; o.write_result = 1'b1; upd = 1'b1; end
         ACT_JZ:  o.branch_taken = flag_z_shadow;
         ACT_JP:  o.branch_taken = !flag_z_shadow && !flag_n_shadow;
         ACT_JN:  o.branch_taken = flag_n_shadow;
         ACT_JNZ: o.branch_taken = !flag_z_shadow;
         ACT_JNP: o.branch_taken = flag_z_shadow || flag_n_shadow;
         ACT_JNN: o.branch_taken = !flag_n_shadow;
         ACT_MOV: begin r = ub; o.write_result = 1'b1; end
         default: ;   // unused codes: no effect
      endcase
      if (upd) begin
         flag_n_shadow = r[31];
         flag_z_shadow = (r == '0);
      end
      if (o.write_result) begin
         o.result_value = r;
      end
      o.flag_negative = flag_n_shadow;
      o.flag_zero     = flag_z_shadow;
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         err_cnt++;
         $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Idle lengths, shared by both sides: mostly short, a few long, and now and
   // then a stretch with no idling at all. side 0 = sender, 1 = receiver.
   // -------------------------------------------------------------------------
   function automatic int unsigned pick_gap(int side);
      int unsigned r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 3) begin
         calm_left[side] = $urandom_range(80, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [31:0] rand_word();
      case ($urandom_range(9, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '1;
         3:       return '0;
         4, 5:    return 32'($urandom_range(40, 0) - 20);   // small, either sign
         6:       return 32'($urandom_range(16'hFFFF, 0));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_shift();
      case ($urandom_range(9, 0))
         0, 1, 2, 3, 4, 5: return 32'($urandom_range(31, 0));
         6:                return 32'($urandom_range(64, 32));      // saturates high
         7:                return 32'(0 - $urandom_range(40, 1));   // counts as 0
         8:                return ($urandom_range(1, 0) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default:          return $urandom();
      endcase
   endfunction

   task automatic queue_req(logic [ACT_W-1:0] act, logic [31:0] a, logic [31:0] b, bit hold);
      pend_req_type p;
      p.rq.action    = act;
      p.rq.operand_a = a;
      p.rq.operand_b = b;
      p.wait_drain   = hold;
      pend_q.push_back(p);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: changes at the falling edge. A request stays on the bus
   // until it is taken; after that, a random gap before the next one.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      pend_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // still waiting for the block to take it
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pend_q.size() == 0 ||
                   (pend_q[0].wait_drain && alu_out_q.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         item = pend_q.pop_front();
         req_data  <= item.rq;
         req_valid <= 1'b1;
         gap_left  = pick_gap(0);
      end
   end

   // Response back-pressure, independent of rsp_valid
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = pick_gap(1);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks a finished response first, then predicts for a request
   // taken at the same edge, so a stray response never meets a fresh guess.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alu_out_q.size() == 0) begin
               err_cnt++;
               $display("%0t ns: response with none outstanding, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               want = alu_out_q.pop_front();
               check_field("result_value", want.result_value, rsp_data.result_value);
               check_field("remainder_value", want.remainder_value, rsp_data.remainder_value);
               check_field("write_result", want.write_result, rsp_data.write_result);
               check_field("write_remainder", want.write_remainder, rsp_data.write_remainder);
               check_field("branch_taken", want.branch_taken, rsp_data.branch_taken);
               check_field("divide_by_zero", want.divide_by_zero, rsp_data.divide_by_zero);
               check_field("flag_negative", want.flag_negative, rsp_data.flag_negative);
               check_field("flag_zero", want.flag_zero, rsp_data.flag_zero);
            end
         end
         if (req_valid && !req_stall) begin
            alu_out_q.push_back(exec_alu(req_data));
            req_accepted++;
         end
         req_fired <= req_valid && !req_stall;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached, %0d of %0d requests taken",
                  $time, req_accepted, req_total);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [ACT_W-1:0] act;
      logic [31:0]      b;
      int unsigned      i;

      // Directed: flags from reset, overflow, each jump on each flag state,
      // divide corner cases, shift saturation, halfword loads, unused codes.
      queue_req(ACT_JP,  32'h0, 32'h0, 1'b0);                   // reset flags: N=0 Z=0
      queue_req(ACT_ADD, 32'h7FFF_FFFF, 32'h1, 1'b0);           // wraps negative
      queue_req(ACT_JN,  32'h0, 32'h0, 1'b0);
      queue_req(ACT_JNN, 32'h0, 32'h0, 1'b0);
      queue_req(ACT_SUB, 32'h5, 32'h5, 1'b0);                   // zero
      queue_req(ACT_JZ,  32'h0, 32'h0, 1'b0);
      queue_req(ACT_JNP, 32'h0, 32'h0, 1'b0);
      queue_req(ACT_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_req(ACT_MUL, 32'h0001_0001, 32'h0000_FFFF, 1'b0);
      queue_req(ACT_DIV, 32'hFFFF_FFF9, 32'h2, 1'b0);           // -7 / 2 toward zero
      queue_req(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);   // quotient overflow
      queue_req(ACT_DIV, 32'h5, 32'h0, 1'b0);                   // divide by zero
      queue_req(ACT_JNZ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);   // after a full drain
      queue_req(ACT_CMP, 32'h3, 32'h7, 1'b0);                   // flags only
      queue_req(ACT_SHL, 32'h1, 32'd40, 1'b0);                  // amount above 31
      queue_req(ACT_SHL, 32'h3, 32'hFFFF_FFFB, 1'b0);           // negative amount
      queue_req(ACT_SHR, 32'h8000_0000, 32'd31, 1'b0);          // sign fill
      queue_req(ACT_SHR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      queue_req(ACT_AND, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0);
      queue_req(ACT_OR,  32'hF0F0_0000, 32'h0000_0F0F, 1'b0);
      queue_req(ACT_XOR, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b0);
      queue_req(ACT_LDL, 32'h1234_5678, 32'hFFFF_ABCD, 1'b0);
      queue_req(ACT_LDH, 32'h1234_5678, 32'hFFFF_ABCD, 1'b0);
      queue_req(ACT_NOT, 32'h0, 32'h0, 1'b0);
      queue_req(ACT_MOV, 32'h0, 32'h8000_0000, 1'b0);
      queue_req(ACT_W'(ACT_MOV + 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);   // first unused code
      queue_req(ACT_TOP_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

      // Random: mostly valid actions, a few unused codes; the operand mix
      // depends on the action so that divides and shifts hit their corners.
      for (i = 0; i < RANDOM_REQS; i++) begin
         if ($urandom_range(99, 0) < 6) begin
            act = ACT_W'($urandom_range(ACT_TOP_CODE, ACT_MOV + 1));
         end else begin
            act = ACT_W'($urandom_range(ACT_MOV, ACT_ADD));
         end
         case (act)
            ACT_DIV:          b = ($urandom_range(9, 0) == 0) ? '0 : rand_word();
            ACT_SHL, ACT_SHR: b = rand_shift();
            default:          b = rand_word();
         endcase
         queue_req(act, rand_word(), b, (i % DRAIN_EVERY) == 0);
      end
      req_total = pend_q.size();

      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every request taken and every response seen
      do begin
         @(negedge clock);
      end while (req_accepted != req_total || alu_out_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
design/alu_nz_pkg.sv
design/alu_with_nz_flags_and_branch_test_top.sv
bench/tb_alu_with_nz_flags_and_branch_test_top.sv
